>>> sv/rbrm_pkg.sv
// ----------------------------------------------------------------------------
// rbrm_pkg
// shared types, address windows and defaults of the rom bank / ram mapper
// ----------------------------------------------------------------------------
`default_nettype none

package rbrm_pkg;

   localparam int unsigned DEF_RAM_BYTES      = 512;
   localparam int unsigned DEF_ROM_BANK_BYTES = 16384;

   localparam int unsigned ADDR_W     = 16;
   localparam int unsigned DATA_W     = 8;
   localparam int unsigned BANK_W     = 4;
   localparam int unsigned ROM_ADDR_W = 18;

   // bus address windows
   localparam logic [ADDR_W-1:0] CTRL_ENABLE_HI = 16'h1FFF;
   localparam logic [ADDR_W-1:0] CTRL_BANK_HI   = 16'h3FFF;
   localparam logic [ADDR_W-1:0] ROM_WIN_LO     = 16'h4000;
   localparam logic [ADDR_W-1:0] ROM_WIN_HI     = 16'h7FFF;
   localparam logic [ADDR_W-1:0] SYS_WIN_LO     = 16'h8000;
   localparam logic [ADDR_W-1:0] SYS_WIN_HI     = 16'hBFFF;
   localparam logic [ADDR_W-1:0] RAM_WIN_LO     = 16'hA000;
   localparam logic [ADDR_W-1:0] RAM_WIN_HI     = 16'hA1FF;

   // window is 512 bytes, so its offset needs 9 bits
   localparam int unsigned RAM_OFF_W = 9;
   // rom window is 16 KiB, so its offset needs 14 bits
   localparam int unsigned ROM_OFF_W = 14;

   localparam logic [DATA_W-1:0] RAM_FILL = 8'hFF;

   typedef enum logic {
      CMD_READ  = 1'b0,
      CMD_WRITE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ROUTE_SYS  = 2'd0,
      ROUTE_ROM  = 2'd1,
      ROUTE_DATA = 2'd2,
      ROUTE_DONE = 2'd3
   } route_type;

   // decoded access, from the decoder to the pipeline
   typedef struct packed {
      route_type             route;
      logic [ROM_ADDR_W-1:0] rom_address;
      logic                  ram_read;
      logic                  ram_write;
      logic                  en_toggle;
      logic                  bank_load;
   } dec_type;

   // stage waiting on the ram read data
   typedef struct packed {
      route_type             route;
      logic [ROM_ADDR_W-1:0] rom_address;
      logic                  ram_read;
      logic                  ram_enable;
   } stage_type;

endpackage

`default_nettype wire

>>> sv/rbrm_if.sv
// ----------------------------------------------------------------------------
// rbrm_req_if / rbrm_rsp_if
// valid/ready channels carrying bus accesses and their routing results
// ----------------------------------------------------------------------------
`default_nettype none

interface rbrm_req_if import rbrm_pkg::*; ();
   logic              valid;
   logic              ready;
   cmd_type           command;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, command, address, write_data, input ready);
   modport sink   (input valid, command, address, write_data, output ready);
endinterface

interface rbrm_rsp_if import rbrm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   route_type             route;
   logic [ROM_ADDR_W-1:0] rom_address;
   logic [DATA_W-1:0]     read_data;

   modport source (output valid, route, rom_address, read_data, input ready);
   modport sink   (input valid, route, rom_address, read_data, output ready);
endinterface

`default_nettype wire

>>> sv/rbrm_decode.sv
// ----------------------------------------------------------------------------
// rbrm_decode
// address decode of one bus access: route, banked rom address, ram index
// ----------------------------------------------------------------------------
`default_nettype none

module rbrm_decode import rbrm_pkg::*; #(
   parameter int unsigned RAM_BYTES      = DEF_RAM_BYTES,
   parameter int unsigned ROM_BANK_BYTES = DEF_ROM_BANK_BYTES
) (
   input  var cmd_type                      command,
   input  var logic [ADDR_W-1:0]            address,
   input  var logic [BANK_W-1:0]            rom_bank,
   output dec_type                          dec,
   output logic [$clog2(RAM_BYTES)-1:0]     ram_index
);

   localparam int unsigned RAM_AW = $clog2(RAM_BYTES);

   logic [RAM_OFF_W-1:0]  ram_rem;
   logic [ROM_OFF_W-1:0]  rom_rem;
   logic                  in_rom;
   logic                  in_ram;
   logic                  in_sys;

   assign in_rom = (address >= ROM_WIN_LO) && (address <= ROM_WIN_HI);
   assign in_ram = (address >= RAM_WIN_LO) && (address <= RAM_WIN_HI);
   assign in_sys = (address >= SYS_WIN_LO) && (address <= SYS_WIN_HI);

   // offset modulo the ram size, restoring subtract of shifted multiples
   always_comb begin
      ram_rem = address[RAM_OFF_W-1:0];
      for (int k = 4; k >= 0; k--) begin
         if ({{(32-RAM_OFF_W){1'b0}}, ram_rem} >= (RAM_BYTES << k)) begin
            ram_rem = ram_rem - RAM_OFF_W'(RAM_BYTES << k);
         end
      end
   end

   assign ram_index = RAM_AW'(ram_rem);

   // offset modulo the bank size, same scheme
   always_comb begin
      rom_rem = address[ROM_OFF_W-1:0];
      for (int k = 3; k >= 0; k--) begin
         if ({{(32-ROM_OFF_W){1'b0}}, rom_rem} >= (ROM_BANK_BYTES << k)) begin
            rom_rem = rom_rem - ROM_OFF_W'(ROM_BANK_BYTES << k);
         end
      end
   end

   always_comb begin
      dec             = '0;
      dec.route       = ROUTE_SYS;
      if (command == CMD_READ) begin
         priority if (in_rom) begin
            dec.route       = ROUTE_ROM;
            dec.rom_address = ({{(ROM_ADDR_W-BANK_W){1'b0}}, rom_bank}
                               * ROM_ADDR_W'(ROM_BANK_BYTES))
                              + ROM_ADDR_W'(rom_rem);
         end else if (in_ram) begin
            dec.route    = ROUTE_DATA;
            dec.ram_read = 1'b1;
         end else begin
            dec.route = ROUTE_SYS;
         end
      end else begin
         priority if (address <= CTRL_ENABLE_HI) begin
            dec.en_toggle = ~address[8];
            dec.route     = ROUTE_DONE;
         end else if (address <= CTRL_BANK_HI) begin
            dec.bank_load = address[8];
            dec.route     = ROUTE_DONE;
         end else if (in_ram) begin
            dec.ram_write = 1'b1;
            dec.route     = ROUTE_DONE;
         end else if (in_sys) begin
            dec.route = ROUTE_SYS;
         end else begin
            dec.route = ROUTE_DONE;
         end
      end
   end

endmodule

`default_nettype wire

>>> sv/rbrm_ram.sv
// ----------------------------------------------------------------------------
// rbrm_ram
// save ram, one write and one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rbrm_ram import rbrm_pkg::*; #(
   parameter int unsigned RAM_BYTES = DEF_RAM_BYTES
) (
   input  var logic                          clock,
   input  var logic                          wr_en,
   input  var logic [$clog2(RAM_BYTES)-1:0]  wr_addr,
   input  var logic [DATA_W-1:0]             wr_data,
   input  var logic                          rd_en,
   input  var logic [$clog2(RAM_BYTES)-1:0]  rd_addr,
   output logic [DATA_W-1:0]                 rd_data
);

   logic [DATA_W-1:0] mem_ff [RAM_BYTES];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/rom_bank_ram_mapper.sv
// ----------------------------------------------------------------------------
// rom_bank_ram_mapper
// cartridge bank controller: banked rom addressing, control writes, save ram
// ----------------------------------------------------------------------------
// path: a req beat goes through the ram read into stage 1, then the output reg
// throughput: one beat per cycle, held while rsp stalls or the clearing pass runs
// reset: bank 1, ram disabled, then a clearing pass writes 0xff to every ram
//   byte (512 by default), one per cycle, with req ready low
`default_nettype none

module rom_bank_ram_mapper import rbrm_pkg::*; #(
   parameter int unsigned RAM_BYTES      = DEF_RAM_BYTES,
   parameter int unsigned ROM_BANK_BYTES = DEF_ROM_BANK_BYTES
) (
   input  var logic       clock,
   input  var logic       reset,
   rbrm_req_if.sink       req_bus,
   rbrm_rsp_if.source     rsp_bus
);

   localparam int unsigned RAM_AW = $clog2(RAM_BYTES);

   // decode of the incoming beat
   dec_type            dec;
   logic [RAM_AW-1:0]  dec_index;

   // control registers
   logic [BANK_W-1:0]  bank_ff;
   logic               en_ff;

   // clearing pass
   logic               clear_ff;
   logic [RAM_AW-1:0]  clear_idx_ff;

   // stage 1: waiting on ram read data
   logic               s1_valid_ff;
   logic               s1_valid_in;
   stage_type          s1_ff;

   // output register
   logic                  out_valid_ff;
   logic                  out_valid_in;
   route_type             out_route_ff;
   logic [ROM_ADDR_W-1:0] out_rom_ff;
   logic [DATA_W-1:0]     out_data_ff;
   logic [DATA_W-1:0]     out_data_in;

   // ram ports
   logic               ram_wr_en;
   logic [RAM_AW-1:0]  ram_wr_addr;
   logic [DATA_W-1:0]  ram_wr_data;
   logic [DATA_W-1:0]  ram_rd_data;

   logic               req_beat;
   logic               rsp_beat;
   logic               s1_move;

   rbrm_decode #(
      .RAM_BYTES      (RAM_BYTES),
      .ROM_BANK_BYTES (ROM_BANK_BYTES)
   ) u_decode (
      .command   (req_bus.command),
      .address   (req_bus.address),
      .rom_bank  (bank_ff),
      .dec       (dec),
      .ram_index (dec_index)
   );

   // handshake: stage 1 drains whenever the output register is free or leaving,
   // so a new beat is taken while a result still waits in the output register
   assign rsp_beat      = out_valid_ff && rsp_bus.ready;
   assign s1_move       = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !clear_ff && (!s1_valid_ff || !out_valid_ff || rsp_bus.ready);
   assign req_beat      = req_bus.valid && req_bus.ready;

   // ram access happens on the beat edge itself; a write and a later read of the
   // same byte never share an edge, so the read always sees the stored value
   always_comb begin
      if (clear_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_idx_ff;
         ram_wr_data = RAM_FILL;
      end else begin
         ram_wr_en   = req_beat && dec.ram_write && en_ff;
         ram_wr_addr = dec_index;
         ram_wr_data = req_bus.write_data;
      end
   end

   rbrm_ram #(
      .RAM_BYTES (RAM_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_beat && dec.ram_read),
      .rd_addr (dec_index),
      .rd_data (ram_rd_data)
   );

   // bank and enable registers, clearing pass sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff      <= BANK_W'(1);
         en_ff        <= 1'b0;
         clear_ff     <= 1'b1;
         clear_idx_ff <= '0;
      end else begin
         if (clear_ff) begin
            if (clear_idx_ff == RAM_AW'(RAM_BYTES - 1)) begin
               clear_ff <= 1'b0;
            end
            clear_idx_ff <= clear_idx_ff + RAM_AW'(1);
         end
         if (req_beat && dec.en_toggle) begin
            en_ff <= ~en_ff;
         end
         if (req_beat && dec.bank_load) begin
            bank_ff <= req_bus.write_data[BANK_W-1:0];
         end
      end
   end

   // pipeline valid bits
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_beat) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_beat) begin
         out_valid_in = 1'b0;
      end

      // disabled ram reads as 0xff, other routes carry zero
      if (!s1_ff.ram_read) begin
         out_data_in = '0;
      end else if (s1_ff.ram_enable) begin
         out_data_in = ram_rd_data;
      end else begin
         out_data_in = RAM_FILL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_ff.route       <= dec.route;
         s1_ff.rom_address <= dec.rom_address;
         s1_ff.ram_read    <= dec.ram_read;
         s1_ff.ram_enable  <= en_ff;
      end
      if (s1_move) begin
         out_route_ff <= s1_ff.route;
         out_rom_ff   <= s1_ff.rom_address;
         out_data_ff  <= out_data_in;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.route       = out_route_ff;
   assign rsp_bus.rom_address = out_rom_ff;
   assign rsp_bus.read_data   = out_data_ff;

   // no beat taken while both stages are full and the output is stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("beat taken with a full pipeline");

   // the clearing pass always follows reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> clear_ff && !req_bus.ready)
      else $error("clearing pass not running after reset");

   // rom address only on rom routes
   a_rom_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_route_ff != ROUTE_ROM |-> out_rom_ff == '0)
      else $error("rom address on a non-rom route");

   // read data only on data routes
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_route_ff != ROUTE_DATA |-> out_data_ff == '0)
      else $error("read data on a non-data route");

   // ram never written by an access while the clearing pass runs
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !req_beat && ram_wr_data == RAM_FILL)
      else $error("access during clearing pass");

endmodule

`default_nettype wire

>>> tb/rom_bank_ram_mapper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_bank_ram_mapper_tb
// drives accesses into the mapper, checks every routing result against
// typed rows or an in-bench model of bank register, ram enable, save ram.
// a short table of directed accesses comes first, then constrained-random
// traffic under several idle/stall patterns and one long sink hold-off.
// ----------------------------------------------------------------------------

module rom_bank_ram_mapper_tb;
   import rbrm_pkg::*;

   localparam int unsigned RAM_BYTES      = DEF_RAM_BYTES;
   localparam int unsigned ROM_BANK_BYTES = DEF_ROM_BANK_BYTES;

   localparam int unsigned RANDOM_BEATS = 1275;
   localparam int unsigned PHASE_BEATS  = 130;
   localparam int unsigned HOLD_AT      = 60;     // random beat that starts the hold-off
   localparam int unsigned HOLD_CYCLES  = 150;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned BUSY_PCT     = 56;
   localparam int unsigned BOTH_PCT     = 8;
   localparam int unsigned RUN_LIMIT_NS = 2_400_000;

   // pacing patterns applied to the two channels
   typedef enum logic [1:0] {
      PACE_FREE = 2'd0,
      PACE_TX   = 2'd1,
      PACE_RX   = 2'd2,
      PACE_BOTH = 2'd3
   } pace_type;

   typedef struct packed {
      cmd_type           command;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
   } bus_access_type;

   typedef struct packed {
      route_type             route;
      logic [ROM_ADDR_W-1:0] rom_address;
      logic [DATA_W-1:0]     read_data;
   } routing_type;

   typedef struct {
      bus_access_type access;
      bit             typed;     // result below is written out by hand
      routing_type    result;
   } table_row_type;

   logic clock;
   logic reset;

   rbrm_req_if req_bus ();
   rbrm_rsp_if rsp_bus ();

   rom_bank_ram_mapper #(
      .RAM_BYTES      (RAM_BYTES),
      .ROM_BANK_BYTES (ROM_BANK_BYTES)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // mirror of the mapper state
   logic [BANK_W-1:0] bank_sel;
   logic              ram_on;
   logic [DATA_W-1:0] save_image [RAM_BYTES];

   routing_type   routes_due [$];
   table_row_type access_table [$];
   int unsigned   mismatches = 0;

   pace_type pace    = PACE_FREE;
   logic     hold_go = 1'b0;

   // clock: 6 ns high, 6 ns low
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // model of one bus access: returns its routing and updates the mirror
   // ------------------------------------------------------------------------
   function automatic routing_type map_access(bus_access_type acc);
      routing_type res;
      int unsigned addr;
      int unsigned ofs;
      addr            = acc.address;
      res.route       = ROUTE_SYS;
      res.rom_address = '0;
      res.read_data   = '0;
      if (acc.command == CMD_READ) begin
         if (acc.address >= ROM_WIN_LO && acc.address <= ROM_WIN_HI) begin
            // offset wraps inside the bank, the full sum wraps at 18 bits
            ofs             = (addr - ROM_WIN_LO) % ROM_BANK_BYTES;
            res.rom_address = ROM_ADDR_W'(bank_sel * ROM_BANK_BYTES + ofs);
            res.route       = ROUTE_ROM;
         end else if (acc.address >= RAM_WIN_LO && acc.address <= RAM_WIN_HI) begin
            res.read_data = ram_on ? save_image[(addr - RAM_WIN_LO) % RAM_BYTES] : RAM_FILL;
            res.route     = ROUTE_DATA;
         end
         // every other read, 0x9800-0x9fff included, goes to system memory
      end else begin
         if (acc.address <= CTRL_ENABLE_HI) begin
            // enable toggles only with address bit 8 clear
            if (!acc.address[8]) ram_on = !ram_on;
            res.route = ROUTE_DONE;
         end else if (acc.address <= CTRL_BANK_HI) begin
            // bank loads only with address bit 8 set
            if (acc.address[8]) bank_sel = acc.write_data[BANK_W-1:0];
            res.route = ROUTE_DONE;
         end else if (acc.address >= RAM_WIN_LO && acc.address <= RAM_WIN_HI) begin
            if (ram_on) save_image[(addr - RAM_WIN_LO) % RAM_BYTES] = acc.write_data;
            res.route = ROUTE_DONE;
         end else if (acc.address >= SYS_WIN_LO && acc.address <= SYS_WIN_HI) begin
            res.route = ROUTE_SYS;
         end else begin
            res.route = ROUTE_DONE;
         end
      end
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // random access: mostly well-aimed at each window, some pure noise
   // ------------------------------------------------------------------------
   function automatic bus_access_type random_access();
      bus_access_type acc;
      int unsigned    pick;
      pick           = $urandom_range(99);
      acc.command    = CMD_READ;
      acc.write_data = DATA_W'($urandom);
      if (pick < 24) begin
         // banked rom fetch
         acc.address = ADDR_W'(ROM_WIN_LO + $urandom_range(ROM_WIN_HI - ROM_WIN_LO));
      end else if (pick < 40) begin
         // save ram read
         acc.address = ADDR_W'(RAM_WIN_LO + $urandom_range(RAM_WIN_HI - RAM_WIN_LO));
      end else if (pick < 58) begin
         // save ram write
         acc.command = CMD_WRITE;
         acc.address = ADDR_W'(RAM_WIN_LO + $urandom_range(RAM_WIN_HI - RAM_WIN_LO));
      end else if (pick < 64) begin
         // enable control area, bit 8 either way
         acc.command = CMD_WRITE;
         acc.address = ADDR_W'($urandom_range(CTRL_ENABLE_HI));
      end else if (pick < 72) begin
         // bank control area, bit 8 either way
         acc.command = CMD_WRITE;
         acc.address = ADDR_W'(CTRL_ENABLE_HI + 1 + $urandom_range(CTRL_BANK_HI - CTRL_ENABLE_HI - 1));
      end else if (pick < 80) begin
         // anywhere in the system window, either direction
         acc.command = cmd_type'($urandom_range(1));
         acc.address = ADDR_W'(SYS_WIN_LO + $urandom_range(SYS_WIN_HI - SYS_WIN_LO));
      end else if (pick < 86) begin
         // just around the ram window edges
         acc.command = cmd_type'($urandom_range(1));
         acc.address = ADDR_W'(16'h9800 + $urandom_range(16'h0C00));
      end else begin
         acc.command = cmd_type'($urandom_range(1));
         acc.address = ADDR_W'($urandom);
      end
      return acc;
   endfunction

   task automatic add_row(cmd_type c, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d,
                          bit typed = 1'b0, route_type r = ROUTE_SYS,
                          logic [ROM_ADDR_W-1:0] ra = '0, logic [DATA_W-1:0] rd = '0);
      table_row_type row;
      row.access             = '{command: c, address: a, write_data: d};
      row.typed              = typed;
      row.result.route       = r;
      row.result.rom_address = ra;
      row.result.read_data   = rd;
      access_table.push_back(row);
   endtask

   // offer one beat after an optional random gap, return once it is taken
   task automatic offer_access(bus_access_type acc, int unsigned gap_pct);
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= acc.command;
      req_bus.address    <= acc.address;
      req_bus.write_data <= acc.write_data;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   function automatic int unsigned tx_gap_pct(pace_type p);
      return (p == PACE_TX) ? BUSY_PCT : (p == PACE_BOTH) ? BOTH_PCT : 0;
   endfunction

   function automatic int unsigned rx_stall_pct(pace_type p);
      return (p == PACE_RX) ? BUSY_PCT : (p == PACE_BOTH) ? BOTH_PCT : 0;
   endfunction

   // ------------------------------------------------------------------------
   // sender: reset, directed table, random traffic, drain, verdict
   // ------------------------------------------------------------------------
   initial begin : sender
      routing_type    res;
      bus_access_type acc;
      pace_type       next_pace;

      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.command    <= CMD_READ;
      req_bus.address    <= '0;
      req_bus.write_data <= '0;

      bank_sel = BANK_W'(1);
      ram_on   = 1'b0;
      foreach (save_image[i]) save_image[i] = RAM_FILL;

      // directed table, bank 1 and ram disabled at the start
      add_row(CMD_READ,  16'h4000, 8'h00, 1, ROUTE_ROM,  18'h04000);
      add_row(CMD_READ,  16'h7FFF, 8'hFF, 1, ROUTE_ROM,  18'h07FFF);
      add_row(CMD_READ,  16'hA000, 8'h00, 1, ROUTE_DATA, '0, 8'hFF);
      add_row(CMD_READ,  16'hA1FF, 8'h00, 1, ROUTE_DATA, '0, 8'hFF);
      add_row(CMD_READ,  16'h9FFF, 8'h00, 1, ROUTE_SYS);    // gap below the ram window
      add_row(CMD_READ,  16'h0000, 8'h00, 1, ROUTE_SYS);
      add_row(CMD_WRITE, 16'h2100, 8'h00, 1, ROUTE_DONE);   // bank 0
      add_row(CMD_READ,  16'h4000, 8'h00, 1, ROUTE_ROM,  18'h00000);
      add_row(CMD_WRITE, 16'h3FFF, 8'hFF, 1, ROUTE_DONE);   // bank 15, upper nibble dropped
      add_row(CMD_READ,  16'h7FFF, 8'h00, 1, ROUTE_ROM,  18'h3FFFF);
      add_row(CMD_WRITE, 16'h2000, 8'h03, 1, ROUTE_DONE);   // bit 8 clear, bank kept
      add_row(CMD_READ,  16'h5555, 8'h00);
      add_row(CMD_WRITE, 16'h0000, 8'h00, 1, ROUTE_DONE);   // ram on
      add_row(CMD_WRITE, 16'hA000, 8'h00, 1, ROUTE_DONE);
      add_row(CMD_WRITE, 16'hA1FF, 8'hA5, 1, ROUTE_DONE);
      add_row(CMD_READ,  16'hA000, 8'hFF, 1, ROUTE_DATA, '0, 8'h00);
      add_row(CMD_READ,  16'hA1FF, 8'h00, 1, ROUTE_DATA, '0, 8'hA5);
      add_row(CMD_WRITE, 16'h1FFF, 8'hFF, 1, ROUTE_DONE);   // bit 8 set, no toggle
      add_row(CMD_READ,  16'hA1FF, 8'h00);
      add_row(CMD_WRITE, 16'h8000, 8'h12, 1, ROUTE_SYS);
      add_row(CMD_WRITE, 16'hA200, 8'h34, 1, ROUTE_SYS);    // just past the ram window
      add_row(CMD_WRITE, 16'h4000, 8'h56, 1, ROUTE_DONE);   // rom area write dropped
      add_row(CMD_WRITE, 16'hFFFF, 8'h78, 1, ROUTE_DONE);
      add_row(CMD_WRITE, 16'h1EFF, 8'h00, 1, ROUTE_DONE);   // ram off again
      add_row(CMD_READ,  16'hA1FF, 8'h00, 1, ROUTE_DATA, '0, 8'hFF);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // ready stays low through the clearing pass, the handshake waits it out
      foreach (access_table[i]) begin
         offer_access(access_table[i].access, 0);
         res = map_access(access_table[i].access);
         routes_due.push_back(access_table[i].typed ? access_table[i].result : res);
      end

      for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
         acc = random_access();
         offer_access(acc, tx_gap_pct(pace));
         routes_due.push_back(map_access(acc));
         // one long hold-off on the sink while the source keeps pushing
         if (n == HOLD_AT) hold_go <= 1'b1;
         if ((n + 1) % PHASE_BEATS == 0) begin
            next_pace = pace_type'(((n + 1) / PHASE_BEATS) % 4);
            pace <= next_pace;
         end
      end
      req_bus.valid <= 1'b0;
      pace          <= PACE_FREE;

      while (routes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // sink: random stalls by pacing pattern, plus the one long hold-off
   // ------------------------------------------------------------------------
   initial begin : sink
      int unsigned hold_left;
      bit          hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rx_stall_pct(pace));
         end
      end
   end

   // ------------------------------------------------------------------------
   // result check: each rsp beat against the oldest expected routing
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      routing_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (routes_due.size() == 0) begin
            $error("unexpected rsp beat: route %0d rom_address %h read_data %h",
                   rsp_bus.route, rsp_bus.rom_address, rsp_bus.read_data);
            mismatches++;
         end else begin
            want = routes_due.pop_front();
            if (rsp_bus.route !== want.route) begin
               $error("route: expected %0d, got %0d", want.route, rsp_bus.route);
               mismatches++;
            end
            if (rsp_bus.rom_address !== want.rom_address) begin
               $error("rom_address: expected %h, got %h", want.rom_address,
                      rsp_bus.rom_address);
               mismatches++;
            end
            if (rsp_bus.read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, rsp_bus.read_data);
               mismatches++;
            end
         end
      end
   end

   // watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("Mismatches found");
      $finish;
   end

endmodule
